>>> design/hkv_pkg.sv
`timescale 1ns / 1ps

package hkv_pkg;

    // Default table geometry.
    localparam int HKV_BUCKETS = 4096;
    localparam int HKV_WAYS    = 4;

    // Multiplier of the bucket hash.
    localparam logic [31:0] HKV_HASH_MULT = 32'h61C8_8645;

    // Operation codes. Bit 1 alone selects a clear, so the spare code clears too.
    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key;
        logic [63:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic [63:0] stored_value;
        logic [1:0]  status;
    } t_out_item;

endpackage

>>> design/hkv_hash.sv
`timescale 1ns / 1ps

module hkv_hash import hkv_pkg::*; #(
    parameter int BUCKETS = HKV_BUCKETS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [63:0]                 i_key,
    output logic                        o_done,
    output logic [$clog2(BUCKETS)-1:0]  o_bucket
);

    localparam int  B_W  = $clog2(BUCKETS);
    localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_MLO  = 3'd1;
    localparam logic [2:0] H_MHI  = 3'd2;
    localparam logic [2:0] H_ADD  = 3'd3;
    localparam logic [2:0] H_RED  = 3'd4;

    logic [2:0]     r_state;
    logic [63:0]    r_key;
    logic [63:0]    r_prod;
    logic [63:0]    r_acc;
    logic [B_W-1:0] r_rem;
    logic [5:0]     r_cnt;
    logic           r_done;
    logic [B_W-1:0] r_bucket;

    logic [31:0]    mul_a;
    logic [63:0]    mul_p;
    logic [B_W:0]   rem_t;
    logic [B_W-1:0] rem_n;

    // The one 32 by 32 multiplier, fed the low half and then the high half of the inverted key.
    assign mul_a = (r_state == H_MLO) ? r_key[31:0] : r_key[63:32];
    assign mul_p = 64'(mul_a) * 64'(HKV_HASH_MULT);

    // One restoring remainder step: shift in the next hash bit and subtract once.
    always_comb begin
        rem_t = {r_rem, r_acc[63]};
        if (rem_t >= (B_W + 1)'(BUCKETS)) begin
            rem_t = rem_t - (B_W + 1)'(BUCKETS);
        end
        rem_n = rem_t[B_W-1:0];
    end

    // Sequencer: two partial products, one accumulate, then the reduction.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    r_key   <= ~i_key;
                    r_state <= H_MLO;
                end
            end
            H_MLO: begin
                r_prod  <= mul_p;
                r_state <= H_MHI;
            end
            H_MHI: begin
                r_acc   <= r_prod;
                r_prod  <= mul_p;
                r_state <= H_ADD;
            end
            H_ADD: begin
                r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                r_rem        <= '0;
                r_cnt        <= '0;
                r_state      <= H_RED;
            end
            H_RED: begin
                if (POW2) begin
                    // A power-of-two bucket count keeps the low bits.
                    r_bucket <= r_acc[B_W-1:0];
                    r_done   <= 1'b1;
                    r_state  <= H_IDLE;
                end else begin
                    r_rem <= rem_n;
                    r_acc <= {r_acc[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_bucket <= rem_n;
                        r_done   <= 1'b1;
                        r_state  <= H_IDLE;
                    end
                end
            end
            default: begin
                r_state <= H_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_bucket;

endmodule

>>> design/hashed_key_value_store_core.sv
`timescale 1ns / 1ps
// Hashed key-value store with fixed-size buckets.
// Input channel: i_in_valid / o_in_stall carry one item (operation, key, new_value);
// it is taken at a clock edge with valid high and stall low. Output channel:
// o_out_valid / i_out_stall carry one result item (stored_value, status) per input.
// Get and set: the bucket hash is formed on the shared multiplier (when BUCKETS is
// not a power of two, the remainder is then formed one bit a cycle), then the fill
// count is read and the ways are compared one at a time through the registered entry
// memory port, up to the fill count; a miss then takes the insert or full decision,
// and the result is loaded into the output register. A clear sweeps the fill memory
// one bucket a cycle. One item is in work at a time; o_in_stall is high from
// acceptance until the result has been loaded into the output register. After reset
// the same sweep runs with o_in_stall high and no result item. A stalled receiver
// holds the result in the output register; the next input item is still taken, and
// its result waits until that register is free.
module hashed_key_value_store_core import hkv_pkg::*; #(
    parameter int BUCKETS = HKV_BUCKETS,
    parameter int WAYS    = HKV_WAYS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int B_W     = $clog2(BUCKETS);
    localparam int E_W     = $clog2(ENTRIES);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W  = $clog2(WAYS + 1);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_FILLRD = 4'd3;
    localparam logic [3:0] S_FILLWT = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_MISS   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // Memories.
    logic [FILL_W-1:0] r_fill_mem [BUCKETS];
    logic [63:0]       r_key_mem  [ENTRIES];
    logic [63:0]       r_data_mem [ENTRIES];

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic              r_clr_report;
    logic [B_W-1:0]    r_sweep;
    t_in_item          r_item;
    logic [B_W-1:0]    r_bucket;
    logic [E_W-1:0]    r_base;
    logic [FILL_W-1:0] r_fill;
    logic [WAY_W-1:0]  r_way;
    logic [FILL_W-1:0] r_fill_q;
    logic [63:0]       r_key_q;
    logic [63:0]       r_data_q;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              in_acc;
    logic              hash_start;
    logic              hash_done;
    logic [B_W-1:0]    hash_bucket;
    logic              is_set;
    logic              hit;
    logic              last_way;
    logic              full;
    logic              out_free;
    logic              fill_we;
    logic [B_W-1:0]    fill_wa;
    logic [FILL_W-1:0] fill_wd;
    logic              key_we;
    logic              data_we;
    logic [E_W-1:0]    e_ra;
    logic [E_W-1:0]    e_wa;
    logic [63:0]       data_wd;

    hkv_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (i_in_item.key),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    // Handshake and decode.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign hash_start = in_acc && !i_in_item.operation[1];
    assign is_set     = (r_item.operation == OP_SET);
    assign hit        = (r_key_q == r_item.key);
    assign last_way   = ((FILL_W'(r_way) + FILL_W'(1)) == r_fill);
    assign full       = (r_fill == FILL_W'(WAYS));
    assign out_free   = !r_out_valid || !i_out_stall;

    // Memory controls.
    always_comb begin
        fill_we = (r_state == S_INIT) || ((r_state == S_MISS) && !full);
        fill_wa = (r_state == S_INIT) ? r_sweep : r_bucket;
        fill_wd = (r_state == S_INIT) ? '0 : r_fill + FILL_W'(1);
        key_we  = (r_state == S_MISS) && !full;
        data_we = key_we || ((r_state == S_CMP) && hit && is_set);
        e_ra    = r_base + E_W'(r_way);
        e_wa    = (r_state == S_MISS) ? r_base + E_W'(r_fill) : e_ra;
        data_wd = is_set ? r_item.new_value : r_item.key;
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[fill_wa] <= fill_wd;
        end
        r_fill_q <= r_fill_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[e_wa] <= r_item.key;
        end
        r_key_q <= r_key_mem[e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            r_data_mem[e_wa] <= data_wd;
        end
        r_data_q <= r_data_mem[e_ra];
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_sweep == B_W'(BUCKETS - 1)) begin
                    n_state = r_clr_report ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_in_item.operation[1] ? S_INIT : S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_state = S_FILLRD;
                end
            end
            S_FILLRD: n_state = S_FILLWT;
            S_FILLWT: begin
                n_state = (r_fill_q == '0) ? S_MISS : S_RD;
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (hit) begin
                    n_state = S_DONE;
                end else if (last_way) begin
                    n_state = S_MISS;
                end else begin
                    n_state = S_RD;
                end
            end
            S_MISS: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        case (r_state)
            S_INIT: begin
                r_sweep <= r_sweep + B_W'(1);
            end
            S_IDLE: begin
                if (in_acc) begin
                    r_item       <= i_in_item;
                    r_clr_report <= 1'b1;
                    r_sweep      <= '0;
                    r_res        <= '{stored_value: 64'd0, status: ST_CLEARED};
                end
            end
            S_FILLRD: begin
                r_base <= E_W'(r_bucket) * E_W'(WAYS);
            end
            S_FILLWT: begin
                r_fill <= r_fill_q;
                r_way  <= '0;
            end
            S_CMP: begin
                if (hit) begin
                    r_res <= '{stored_value: is_set ? r_item.new_value : r_data_q,
                               status: ST_FOUND};
                end else begin
                    r_way <= r_way + WAY_W'(1);
                end
            end
            S_MISS: begin
                if (full) begin
                    r_res <= '{stored_value: r_item.key, status: ST_FULL};
                end else begin
                    r_res <= '{stored_value: data_wd, status: ST_INSERTED};
                end
            end
            default: begin
            end
        endcase
        if (hash_done) begin
            r_bucket <= hash_bucket;
        end
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_sweep      <= '0;
            r_clr_report <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
            r_out_item  <= r_res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/hkv_checker.sv
`timescale 1ns / 1ps

module hkv_checker import hkv_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result item stays and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item dropped or changed while stalled");

    // Reset starts the clearing sweep: no result and no input taken.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("block not held off after reset");

    // Once an item is taken the block is busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while the first is in work");

    // A clear reports a zero value.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_CLEARED) |-> o_out_item.stored_value == 64'd0)
        else $error("clear result carries a non-zero value");

endmodule

bind hashed_key_value_store_core hkv_checker u_hkv_checker (.*);

>>> bench/hkv_store_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the key-value store. Each item taken on the input
// side is applied to a private copy of the table, and the result it should
// give is queued; results leaving the block are compared with that queue in
// order.
module hkv_store_checker import hkv_pkg::*; #(
    parameter int BUCKETS = HKV_BUCKETS,
    parameter int WAYS    = HKV_WAYS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    // Keeps the log readable when the block is badly broken; failures are
    // still counted beyond this.
    localparam int REPORT_LIMIT = 200;

    int unsigned bucket_used [BUCKETS];
    logic [63:0] slot_key    [BUCKETS][WAYS];
    logic [63:0] slot_data   [BUCKETS][WAYS];
    t_out_item   awaited_q   [$];
    int          report_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        report_count = 0;
    end

    // Applies one item to the table copy and returns the result it gives.
    function automatic t_out_item apply_access(t_in_item item);
        t_out_item   res;
        logic [63:0] hash;
        int unsigned bkt;
        int unsigned fill;
        int          hit_way;
        // Only bit 1 of the operation is decoded, so the spare code clears too.
        if ((item.operation & OP_CLEAR) != '0) begin
            foreach (bucket_used[i]) bucket_used[i] = 0;
            res.stored_value = '0;
            res.status       = ST_CLEARED;
            return res;
        end
        hash = (~item.key) * {32'd0, HKV_HASH_MULT};
        bkt  = int'(hash % 64'(BUCKETS));
        fill = bucket_used[bkt];
        // Only ways below the fill count hold live entries.
        hit_way = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (w < fill && hit_way < 0 && slot_key[bkt][w] == item.key) begin
                hit_way = w;
            end
        end
        if (hit_way >= 0) begin
            if (item.operation == OP_SET) begin
                slot_data[bkt][hit_way] = item.new_value;
            end
            res.stored_value = slot_data[bkt][hit_way];
            res.status       = ST_FOUND;
        end else if (fill >= WAYS) begin
            // A miss in a full bucket stores nothing and echoes the key.
            res.stored_value = item.key;
            res.status       = ST_FULL;
        end else begin
            // A get inserts the key as its own data word.
            slot_key[bkt][fill]  = item.key;
            slot_data[bkt][fill] = (item.operation == OP_SET) ? item.new_value : item.key;
            bucket_used[bkt]     = fill + 1;
            res.stored_value     = slot_data[bkt][fill];
            res.status           = ST_INSERTED;
        end
        return res;
    endfunction

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        o_fail_count++;
        if (report_count < REPORT_LIMIT) begin
            report_count++;
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Results are checked before new items are queued; a result can never
    // belong to an item taken at the same edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (bucket_used[i]) bucket_used[i] = 0;
            awaited_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_q.size() == 0) begin
                    report("result item with nothing awaited, stored_value",
                           '0, i_out_item.stored_value);
                end else begin
                    want = awaited_q.pop_front();
                    if (i_out_item.stored_value !== want.stored_value) begin
                        report("stored_value", want.stored_value, i_out_item.stored_value);
                    end
                    if (i_out_item.status !== want.status) begin
                        report("status", 64'(want.status), 64'(i_out_item.status));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_q.push_back(apply_access(i_in_item));
            end
        end
        o_pending = awaited_q.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

// Drives the key-value store with a directed opening and then random gets,
// sets and clears. Most random keys either repeat recent keys or land in a
// handful of crowded buckets, so hits, inserts and full buckets all occur
// often. Both sides idle at random; checking is done by the checker module.
module tb;
    import hkv_pkg::*;

    localparam int          HOT_COUNT    = 6;
    localparam int          POOL_DEPTH   = 48;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RANDOM_ITEMS = 1030;
    localparam int          CLEAR_BUDGET = 25;
    localparam logic [63:0] INDEX_MASK   = 64'(HKV_BUCKETS - 1);
    // Spare operation code, decoded by the block as a clear.
    localparam logic [1:0]  OP_CLEAR_SPARE = OP_CLEAR | OP_SET;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_item;
    int          fail_count;
    int          pending;
    bit          hold_req;
    int unsigned sender_quiet;
    logic [63:0] hot_index [HOT_COUNT];
    logic [63:0] key_pool  [$];

    hashed_key_value_store_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    hkv_store_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #2_500_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: runs of stall and no stall, with occasional quiet stretches
    // and, on request, one long hold-off so that the block backs up.
    initial begin : result_sink
        int unsigned run_left;
        int unsigned roll;
        bit          level;
        out_stall = 1'b0;
        run_left  = 0;
        level     = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 8) begin
                        level    = 1'b0;
                        run_left = $urandom_range(50, 200);
                    end else if (roll < 60) begin
                        level    = 1'b0;
                        run_left = $urandom_range(1, 4);
                    end else if (roll < 92) begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 3);
                    end else begin
                        level    = 1'b1;
                        run_left = $urandom_range(15, 60);
                    end
                end
                out_stall <= level;
                run_left--;
            end
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item pack_access(logic [1:0] op, logic [63:0] key,
                                             logic [63:0] value);
        t_in_item item;
        item.operation = op;
        item.key       = key;
        item.new_value = value;
        return item;
    endfunction

    // Presents one item until it is taken, then leaves a random gap. Called
    // and returning at a falling edge.
    task automatic offer(t_in_item item);
        int unsigned gap;
        int unsigned roll;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        roll = $urandom_range(0, 99);
        if (sender_quiet > 0) begin
            sender_quiet--;
            gap = 0;
        end else if (roll < 55) begin
            gap = 0;
        end else if (roll < 88) begin
            gap = $urandom_range(1, 3);
        end else if (roll < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stops offering and waits until every result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial begin : stimulus
        logic [63:0] twin [5];
        logic [63:0] key;
        logic [63:0] value;
        logic [1:0]  op;
        int unsigned roll;
        int unsigned clears_left;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        hold_req     = 1'b0;
        sender_quiet = 0;

        // Crowded buckets for the random part, among them the keys with all-zero and all-one low bits.
        hot_index[0] = '0;
        hot_index[1] = INDEX_MASK;
        for (int i = 2; i < HOT_COUNT; i++) hot_index[i] = rand_word() & INDEX_MASK;
        // Keys that share their low bits share a bucket.
        for (int i = 0; i < 5; i++) begin
            twin[i] = ((rand_word() & ~INDEX_MASK) | (64'h5A3 & INDEX_MASK)) ^ (64'(i) << 60);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extreme keys and values: insert by get, overwrite by set, then find.
        offer(pack_access(OP_GET, '0, rand_word()));
        offer(pack_access(OP_GET, '1, '0));
        offer(pack_access(OP_SET, '0, '1));
        offer(pack_access(OP_GET, '0, '0));
        offer(pack_access(OP_SET, '0, '0));
        offer(pack_access(OP_SET, 64'h8000_0000_0000_0001, 64'hA5A5_5A5A_0F0F_F0F0));
        // Fill one bucket, then miss in it with a get and a set.
        offer(pack_access(OP_SET, twin[0], 64'h0123_4567_89AB_CDEF));
        offer(pack_access(OP_GET, twin[1], rand_word()));
        offer(pack_access(OP_SET, twin[2], '1));
        offer(pack_access(OP_GET, twin[3], '0));
        offer(pack_access(OP_GET, twin[4], rand_word()));
        offer(pack_access(OP_SET, twin[4], rand_word()));
        // Hits still work in a full bucket.
        offer(pack_access(OP_GET, twin[2], rand_word()));
        offer(pack_access(OP_SET, twin[1], 64'hFEDC_BA98_7654_3210));
        // Clear with both codes; earlier keys come back as new inserts.
        offer(pack_access(OP_CLEAR, rand_word(), rand_word()));
        offer(pack_access(OP_GET, twin[1], rand_word()));
        offer(pack_access(OP_GET, '0, '1));
        offer(pack_access(OP_CLEAR_SPARE, '1, '1));
        offer(pack_access(OP_GET, twin[0], '0));
        offer(pack_access(OP_SET, '1, '0));
        drain();

        clears_left = CLEAR_BUDGET;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Long hold-off at the output while items keep coming back to back.
            if (n == 300) begin
                hold_req     = 1'b1;
                sender_quiet = 40;
            end
            if (n == 650) drain();
            if (n % 170 == 85) sender_quiet = 30;

            roll = $urandom_range(0, 99);
            if (roll < 3 && clears_left > 0) begin
                clears_left--;
                op = $urandom_range(0, 1) ? OP_CLEAR : OP_CLEAR_SPARE;
                offer(pack_access(op, rand_word(), rand_word()));
            end else begin
                op = (roll < 51) ? OP_GET : OP_SET;
                // Recent keys for hits, crowded buckets for full misses.
                roll = $urandom_range(0, 9);
                if (roll < 4 && key_pool.size() > 0) begin
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end else begin
                    if (roll < 8) begin
                        key = (rand_word() & ~INDEX_MASK)
                              | hot_index[$urandom_range(0, HOT_COUNT - 1)];
                    end else begin
                        key = rand_word();
                    end
                    key_pool.push_back(key);
                    if (key_pool.size() > POOL_DEPTH) key_pool.delete(0);
                end
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    value = '0;
                end else if (roll == 1) begin
                    value = '1;
                end else begin
                    value = rand_word();
                end
                offer(pack_access(op, key, value));
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> hashed_key_value_store_core.f
design/hkv_pkg.sv
design/hkv_hash.sv
design/hashed_key_value_store_core.sv
design/hkv_checker.sv
bench/hkv_store_checker.sv
bench/tb.sv
